// ===== src/idct8_lifting_walsh_macros.svh =====
// Assertion macros shared by the row IDCT modules.
// Depends on nothing; included by the files that carry checks.
`ifndef IDCT8_LIFTING_WALSH_MACROS_SVH
`define IDCT8_LIFTING_WALSH_MACROS_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define IDCT8LW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("idct8lw check failed");
// Check that also holds during reset.
`define IDCT8LW_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("idct8lw reset check failed");
`else
`define IDCT8LW_ASSERT(lbl, clk, rst_n, prop)
`define IDCT8LW_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== src/idct8lw_pkg.sv =====
// Shared constants of the 8-point lifting IDCT with Walsh-Hadamard output stage.
// Depends on nothing.
package idct8lw_pkg;

  // Default coefficient width.
  localparam int COEF_WIDTH_DEF = 16;
  // Width of one output sample.
  localparam int SAMPLE_WIDTH = 22;
  // Headroom bits carried through the lifting and butterfly stages.
  localparam int GUARD_BITS = 10;
  // Number of items in one row.
  localparam int ROW_LEN = 8;
  // Register stages of the lifting rotations and of the butterfly.
  localparam int ROT_STAGES = 6;
  localparam int WHT_STAGES = 3;

endpackage

// ===== src/idct8lw_if.sv =====
// Valid/ready channel interfaces for coefficient rows and sample rows.
// Depends on idct8lw_pkg.
interface idct8lw_in_if #(
  parameter int COEF_WIDTH = idct8lw_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_0;
  logic signed [COEF_WIDTH-1:0] coef_1;
  logic signed [COEF_WIDTH-1:0] coef_2;
  logic signed [COEF_WIDTH-1:0] coef_3;
  logic signed [COEF_WIDTH-1:0] coef_4;
  logic signed [COEF_WIDTH-1:0] coef_5;
  logic signed [COEF_WIDTH-1:0] coef_6;
  logic signed [COEF_WIDTH-1:0] coef_7;

  modport source (
    output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
    input  ready
  );
  modport sink (
    input  valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
    output ready
  );
endinterface

interface idct8lw_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_0;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_1;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_2;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_3;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_4;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_5;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_6;
  logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0] sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

// ===== src/idct8lw_rot.sv =====
// Lifting rotation pipeline: bit reversal, five lifting rotations, second bit reversal.
// Depends on idct8lw_pkg and idct8_lifting_walsh_macros.svh.
`include "idct8_lifting_walsh_macros.svh"

module idct8lw_rot #(
  parameter int COEF_WIDTH = idct8lw_pkg::COEF_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic signed [COEF_WIDTH-1:0]                        in_coef [idct8lw_pkg::ROW_LEN],
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic signed [COEF_WIDTH+idct8lw_pkg::GUARD_BITS-1:0] out_data [idct8lw_pkg::ROW_LEN]
);
  import idct8lw_pkg::*;

  localparam int IW = COEF_WIDTH + GUARD_BITS;
  localparam int NST = ROT_STAGES;

  typedef logic signed [IW-1:0] word_t;

  word_t s0    [ROW_LEN];
  word_t d_nxt [NST][ROW_LEN];
  word_t d_r   [NST][ROW_LEN];
  logic  v_r   [NST];
  logic  en    [NST];

  // Sign-extend the incoming row into the working width.
  always_comb begin
    for (int k = 0; k < ROW_LEN; k++) begin
      s0[k] = word_t'(in_coef[k]);
    end
  end

  // Lanes keep the input coefficient index through the first three stages.
  // Stage 0: first lift of the -pi/8, 7pi/16 and 3pi/16 rotations.
  // Stage 1: second lift of the same rotations.
  // Stage 2: third lift, with the three intermediates negated.
  // Stages 3 to 5: the two 3pi/8 rotations, one lift per stage.
  always_comb begin
    d_nxt[0] = s0;
    d_nxt[0][2] = s0[2] - (s0[6] >>> 2);
    d_nxt[0][1] = s0[1] + (((s0[7] <<< 1) + s0[7]) >>> 2);
    d_nxt[0][3] = s0[3] - (s0[5] >>> 2);

    d_nxt[1] = d_r[0];
    d_nxt[1][6] = d_r[0][6] + (d_r[0][2] >>> 1);
    d_nxt[1][7] = d_r[0][7] - d_r[0][1];
    d_nxt[1][5] = d_r[0][5] + (d_r[0][3] >>> 1);

    d_nxt[2] = d_r[1];
    d_nxt[2][2] = d_r[1][2] - (d_r[1][6] >>> 2);
    d_nxt[2][1] = -(d_r[1][1] + (((d_r[1][7] <<< 1) + d_r[1][7]) >>> 2));
    d_nxt[2][7] = -d_r[1][7];
    d_nxt[2][3] = -(d_r[1][3] - (d_r[1][5] >>> 2));

    d_nxt[3] = d_r[2];
    d_nxt[3][3] = d_r[2][3] + (((d_r[2][7] <<< 2) + d_r[2][7]) >>> 3);
    d_nxt[3][1] = d_r[2][1] + (((d_r[2][5] <<< 2) + d_r[2][5]) >>> 3);

    d_nxt[4] = d_r[3];
    d_nxt[4][7] = d_r[3][7] - d_r[3][3];
    d_nxt[4][5] = d_r[3][5] - d_r[3][1];

    d_nxt[5] = d_r[4];
    d_nxt[5][3] = d_r[4][3] + (((d_r[4][7] <<< 2) + d_r[4][7]) >>> 3);
    d_nxt[5][1] = d_r[4][1] + (((d_r[4][5] <<< 2) + d_r[4][5]) >>> 3);
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  // Second bit reversal: hand the row over in butterfly order.
  assign out_data[0] = d_r[NST-1][0];
  assign out_data[1] = d_r[NST-1][3];
  assign out_data[2] = d_r[NST-1][2];
  assign out_data[3] = d_r[NST-1][7];
  assign out_data[4] = d_r[NST-1][4];
  assign out_data[5] = d_r[NST-1][1];
  assign out_data[6] = d_r[NST-1][6];
  assign out_data[7] = d_r[NST-1][5];

  // A stalled row stays put, and a drained output never blocks the input.
  `IDCT8LW_ASSERT(a_rot_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data[3])))
  `IDCT8LW_ASSERT(a_rot_ready_drained, clk, rst_n, !out_valid |-> in_ready)

endmodule

// ===== src/idct8lw_wht.sv =====
// Walsh-ordered 8-point Hadamard butterfly, one add level per register stage.
// Depends on idct8lw_pkg and idct8_lifting_walsh_macros.svh.
`include "idct8_lifting_walsh_macros.svh"

module idct8lw_wht #(
  parameter int COEF_WIDTH = idct8lw_pkg::COEF_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic signed [COEF_WIDTH+idct8lw_pkg::GUARD_BITS-1:0] in_data [idct8lw_pkg::ROW_LEN],
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic signed [idct8lw_pkg::SAMPLE_WIDTH-1:0]         out_sample [idct8lw_pkg::ROW_LEN]
);
  import idct8lw_pkg::*;

  localparam int IW = COEF_WIDTH + GUARD_BITS;
  localparam int NST = WHT_STAGES;

  typedef logic signed [IW-1:0] word_t;

  word_t d_nxt [NST][ROW_LEN];
  word_t d_r   [NST][ROW_LEN];
  logic  v_r   [NST];
  logic  en    [NST];

  // Level 0 forms pair sums and differences, level 1 combines pairs,
  // level 2 produces the samples in Walsh order.
  always_comb begin
    d_nxt[0][0] = in_data[0] + in_data[1];
    d_nxt[0][1] = in_data[4] + in_data[5];
    d_nxt[0][2] = in_data[2] + in_data[3];
    d_nxt[0][3] = in_data[6] + in_data[7];
    d_nxt[0][4] = in_data[0] - in_data[1];
    d_nxt[0][5] = in_data[4] - in_data[5];
    d_nxt[0][6] = in_data[2] - in_data[3];
    d_nxt[0][7] = in_data[6] - in_data[7];

    d_nxt[1][0] = d_r[0][0] + d_r[0][2];
    d_nxt[1][1] = d_r[0][1] + d_r[0][3];
    d_nxt[1][2] = d_r[0][0] - d_r[0][2];
    d_nxt[1][3] = d_r[0][1] - d_r[0][3];
    d_nxt[1][4] = d_r[0][4] - d_r[0][6];
    d_nxt[1][5] = d_r[0][5] - d_r[0][7];
    d_nxt[1][6] = d_r[0][4] + d_r[0][6];
    d_nxt[1][7] = d_r[0][5] + d_r[0][7];

    d_nxt[2][0] = d_r[1][0] + d_r[1][1];
    d_nxt[2][1] = d_r[1][0] - d_r[1][1];
    d_nxt[2][2] = d_r[1][2] - d_r[1][3];
    d_nxt[2][3] = d_r[1][2] + d_r[1][3];
    d_nxt[2][4] = d_r[1][4] + d_r[1][5];
    d_nxt[2][5] = d_r[1][4] - d_r[1][5];
    d_nxt[2][6] = d_r[1][6] - d_r[1][7];
    d_nxt[2][7] = d_r[1][6] + d_r[1][7];
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  // The last stage is the output register; samples wrap to the output width.
  always_comb begin
    for (int k = 0; k < ROW_LEN; k++) begin
      out_sample[k] = SAMPLE_WIDTH'(d_r[NST-1][k]);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  // An accepted row always lands in the first stage.
  `IDCT8LW_ASSERT(a_wht_load, clk, rst_n, (in_valid && in_ready) |=> v_r[0])

endmodule

// ===== src/idct8_lifting_walsh.sv =====
// Top level of the integer 8-point row IDCT (lifting rotations plus Walsh-Hadamard).
// Depends on idct8lw_pkg, idct8lw_if, idct8lw_rot, idct8lw_wht and the macro header.
//
//   channel | direction | handshake         | payload
//   in_ch   | sink      | valid/ready       | coef_0 .. coef_7, COEF_WIDTH bits signed
//   out_ch  | source    | valid/ready       | sample_0 .. sample_7, 22 bits signed
//
// One row is accepted per cycle until an out_ch stall fills every stage; a row passes
// through six lifting stages and three butterfly stages.
// Reset clears only the stage valid bits; data registers are not reset.
// When out_ch stalls, rows stay in their stages and empty stages keep filling,
// so in_ch.ready drops only when all nine stages hold a row.
`include "idct8_lifting_walsh_macros.svh"

module idct8_lifting_walsh #(
  parameter int COEF_WIDTH = idct8lw_pkg::COEF_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  idct8lw_in_if.sink         in_ch,
  idct8lw_out_if.source      out_ch
);
  import idct8lw_pkg::*;

  localparam int IW = COEF_WIDTH + GUARD_BITS;

  logic signed [COEF_WIDTH-1:0]   coef      [ROW_LEN];
  logic signed [IW-1:0]           mid_data  [ROW_LEN];
  logic signed [SAMPLE_WIDTH-1:0] sample    [ROW_LEN];
  logic                           mid_valid;
  logic                           mid_ready;

  // Gather the row from the input channel.
  assign coef[0] = in_ch.coef_0;
  assign coef[1] = in_ch.coef_1;
  assign coef[2] = in_ch.coef_2;
  assign coef[3] = in_ch.coef_3;
  assign coef[4] = in_ch.coef_4;
  assign coef[5] = in_ch.coef_5;
  assign coef[6] = in_ch.coef_6;
  assign coef[7] = in_ch.coef_7;

  // Lifting rotations.
  idct8lw_rot #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_coef   (coef),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Walsh-Hadamard butterfly and output register.
  idct8lw_wht #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_wht (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_data    (mid_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (sample)
  );

  // Scatter the samples onto the output channel.
  assign out_ch.sample_0 = sample[0];
  assign out_ch.sample_1 = sample[1];
  assign out_ch.sample_2 = sample[2];
  assign out_ch.sample_3 = sample[3];
  assign out_ch.sample_4 = sample[4];
  assign out_ch.sample_5 = sample[5];
  assign out_ch.sample_6 = sample[6];
  assign out_ch.sample_7 = sample[7];

  // Nothing is offered on the output right after a reset cycle.
  `IDCT8LW_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_ch.valid)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the integer 8-point row IDCT with Walsh-Hadamard output stage.
// Depends on idct8lw_pkg, the idct8lw_in_if/idct8lw_out_if interfaces and idct8_lifting_walsh.
module testbench;
  import idct8lw_pkg::*;

  localparam int COEF_W      = COEF_WIDTH_DEF;
  localparam int RAND_ROWS   = 1950;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // Bit-reversed index order used before and after the lifting stages.
  localparam int BITREV [ROW_LEN] = '{0, 4, 2, 6, 1, 5, 3, 7};

  typedef logic [ROW_LEN-1:0][COEF_W-1:0]       coef_row_t;
  typedef logic [ROW_LEN-1:0][SAMPLE_WIDTH-1:0] sample_row_t;

  logic clk;
  logic rst_n;

  idct8lw_in_if #(.COEF_WIDTH(COEF_W)) coef_ch ();
  idct8lw_out_if                       sample_ch ();

  idct8_lifting_walsh #(.COEF_WIDTH(COEF_W)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (coef_ch),
    .out_ch (sample_ch)
  );

  coef_row_t   pending_rows [$];
  sample_row_t expected_samples [$];
  int          rows_in;
  int          err_cnt;
  int          quiet_cycles;
  bit          coef_taken;

  // Inverse 3pi/8 lifting rotation, used twice in the final lifting stage.
  function automatic void lift_3pi8(input longint a, input longint b,
                                    output longint x, output longint y);
    longint r;
    r = a + ((5 * b) >>> 3);
    y = b - r;
    x = r + ((5 * y) >>> 3);
  endfunction

  // Expected sample row for one coefficient row.
  function automatic sample_row_t idct_row(coef_row_t row);
    longint c [ROW_LEN];
    longint b [ROW_LEN];
    longint t [ROW_LEN];
    longint w [ROW_LEN];
    longint u5, u6, u7, u8, r;
    longint p0, p1, p2, p3, m0, m1, m2, m3, q0, q1, q2, q3, e0, e1, e2, e3;
    longint y [ROW_LEN];
    sample_row_t res;
    for (int k = 0; k < ROW_LEN; k++) begin
      c[k] = longint'($signed(row[k]));
    end
    for (int k = 0; k < ROW_LEN; k++) begin
      b[k] = c[BITREV[k]];
    end
    t[0] = b[0];
    t[1] = b[1];
    // Inverse -pi/8 on the pair (b2, b3).
    r    = b[2] - (b[3] >>> 2);
    t[3] = b[3] + (r >>> 1);
    t[2] = r - (t[3] >>> 2);
    // Inverse 7pi/16 on (b4, b7).
    r  = b[4] + ((3 * b[7]) >>> 2);
    u7 = b[7] - r;
    u6 = r + ((3 * u7) >>> 2);
    // Inverse 3pi/16 on (b5, b6).
    r  = b[6] - (b[5] >>> 2);
    u8 = b[5] + (r >>> 1);
    u5 = r - (u8 >>> 2);
    // Three intermediates enter the 3pi/8 stages negated.
    u5 = -u5;
    u6 = -u6;
    u7 = -u7;
    lift_3pi8(u5, u7, t[4], t[6]);
    lift_3pi8(u6, u8, t[5], t[7]);
    for (int k = 0; k < ROW_LEN; k++) begin
      w[k] = t[BITREV[k]];
    end
    // Walsh-Hadamard butterfly in Walsh order.
    p0 = w[0] + w[1]; p1 = w[4] + w[5]; p2 = w[2] + w[3]; p3 = w[6] + w[7];
    m0 = w[0] - w[1]; m1 = w[4] - w[5]; m2 = w[2] - w[3]; m3 = w[6] - w[7];
    q0 = p0 + p2; q1 = p1 + p3; q2 = p0 - p2; q3 = p1 - p3;
    e0 = m0 - m2; e1 = m1 - m3; e2 = m0 + m2; e3 = m1 + m3;
    y[0] = q0 + q1; y[1] = q0 - q1;
    y[2] = q2 - q3; y[3] = q2 + q3;
    y[4] = e0 + e1; y[5] = e0 - e1;
    y[6] = e2 - e3; y[7] = e2 + e3;
    for (int k = 0; k < ROW_LEN; k++) begin
      res[k] = y[k][SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

  // Idle percentage of the sender or the receiver for the current phase.
  function automatic int idle_pct(bit is_sender);
    if (rows_in < (RAND_ROWS + 25) / 3) begin
      return is_sender ? 34 : 58;
    end else if (rows_in < 2 * (RAND_ROWS + 25) / 3) begin
      return is_sender ? 58 : 34;
    end
    return 0;
  endfunction

  // One random coefficient, drawn from one of several value classes.
  function automatic logic [COEF_W-1:0] rand_coef(int mode);
    case (mode)
      0: begin
        return COEF_W'($urandom);
      end
      1: begin
        return COEF_W'($signed($urandom_range(0, 64)) - 32);
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return '1;
          default: return COEF_W'($urandom);
        endcase
      end
      default: begin
        return ($urandom_range(0, 3) == 0) ? COEF_W'($urandom) : '0;
      end
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every input from time zero.
  initial begin
    coef_ch.valid    = 1'b0;
    coef_ch.coef_0   = '0;
    coef_ch.coef_1   = '0;
    coef_ch.coef_2   = '0;
    coef_ch.coef_3   = '0;
    coef_ch.coef_4   = '0;
    coef_ch.coef_5   = '0;
    coef_ch.coef_6   = '0;
    coef_ch.coef_7   = '0;
    sample_ch.ready  = 1'b0;
  end

  // Coefficient row driver: presents the next pending row at the falling edge.
  always @(negedge clk) begin
    coef_row_t row;
    if (rst_n && (!coef_ch.valid || coef_taken)) begin
      if (pending_rows.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        row = pending_rows.pop_front();
        coef_ch.coef_0 <= row[0];
        coef_ch.coef_1 <= row[1];
        coef_ch.coef_2 <= row[2];
        coef_ch.coef_3 <= row[3];
        coef_ch.coef_4 <= row[4];
        coef_ch.coef_5 <= row[5];
        coef_ch.coef_6 <= row[6];
        coef_ch.coef_7 <= row[7];
        coef_ch.valid  <= 1'b1;
      end else begin
        coef_ch.valid <= 1'b0;
      end
    end
  end

  // Sample row receiver back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      sample_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Monitor: predicts on accepted coefficient rows and checks accepted sample rows.
  always @(posedge clk) begin
    coef_row_t   row;
    sample_row_t got;
    sample_row_t want;
    bit          fired;
    fired      = 1'b0;
    coef_taken = 1'b0;
    if (rst_n) begin
      if (coef_ch.valid && coef_ch.ready) begin
        row = {coef_ch.coef_7, coef_ch.coef_6, coef_ch.coef_5, coef_ch.coef_4,
               coef_ch.coef_3, coef_ch.coef_2, coef_ch.coef_1, coef_ch.coef_0};
        expected_samples.push_back(idct_row(row));
        rows_in++;
        coef_taken = 1'b1;
        fired      = 1'b1;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        fired = 1'b1;
        got = {sample_ch.sample_7, sample_ch.sample_6, sample_ch.sample_5,
               sample_ch.sample_4, sample_ch.sample_3, sample_ch.sample_2,
               sample_ch.sample_1, sample_ch.sample_0};
        if (expected_samples.size() == 0) begin
          $error("unexpected sample row");
          err_cnt++;
        end else begin
          want = expected_samples.pop_front();
          for (int k = 0; k < ROW_LEN; k++) begin
            if (got[k] !== want[k]) begin
              $error("sample_%0d: expected %0d, got %0d", k,
                     $signed(want[k]), $signed(got[k]));
              err_cnt++;
            end
          end
        end
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  initial begin
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("idct8_lifting_walsh: mismatch");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    coef_row_t row;
    int        mode;
    rows_in      = 0;
    err_cnt      = 0;
    quiet_cycles = 0;
    coef_taken   = 1'b0;
    rst_n        = 1'b0;

    // Directed rows: zeros, extremes, alternating signs and single impulses.
    pending_rows.push_back('0);
    pending_rows.push_back('1);
    pending_rows.push_back({ROW_LEN{COEF_MAX}});
    pending_rows.push_back({ROW_LEN{COEF_MIN}});
    for (int k = 0; k < ROW_LEN; k++) begin
      row[k] = k[0] ? COEF_MIN : COEF_MAX;
    end
    pending_rows.push_back(row);
    pending_rows.push_back(~row);
    for (int k = 0; k < ROW_LEN; k++) begin
      row    = '0;
      row[k] = COEF_MAX;
      pending_rows.push_back(row);
      row[k] = COEF_MIN;
      pending_rows.push_back(row);
    end

    // Random rows mixing full-range, small, extreme and sparse values.
    for (int n = 0; n < RAND_ROWS; n++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < ROW_LEN; k++) begin
        row[k] = rand_coef(mode);
      end
      pending_rows.push_back(row);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_rows.size() == 0);
    @(posedge clk);
    while (coef_ch.valid) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && expected_samples.size() == 0) begin
      $display("idct8_lifting_walsh: match");
    end else begin
      $display("idct8_lifting_walsh: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/idct8lw_pkg.sv
src/idct8lw_if.sv
src/idct8lw_rot.sv
src/idct8lw_wht.sv
src/idct8_lifting_walsh.sv
sim/testbench.sv
